### src/rpn_pkg.sv
// Shared types and constants for the postfix digit stack evaluator.
`timescale 1ns / 1ps

package rpn_pkg;

    localparam int WORD_W      = 32;
    localparam int SYM_W       = 8;
    localparam int STATUS_W    = 3;
    localparam int DIV_CNT_W   = 5;
    localparam int OUT_TDATA_W = 40;

    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [SYM_W-1:0] CH_COLON = 8'h3A;
    localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd4;

    typedef logic [WORD_W-1:0] word_t;

    // What a stack cell loads on the next edge.
    typedef enum logic [1:0]
    {
        CELL_HOLD    = 2'd0,
        CELL_SHALLOW = 2'd1,
        CELL_DEEP    = 2'd2
    } cell_op_t;

    typedef enum logic [1:0]
    {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } alu_op_t;

    typedef struct packed
    {
        logic    start;
        alu_op_t op;
    } alu_ctrl_t;

endpackage

### src/rpn_cell.sv
// One entry of the operand stack, linked to its shallower and deeper neighbors.
`timescale 1ns / 1ps

module rpn_cell
(
    input  logic              clk,
    input  rpn_pkg::cell_op_t op,
    input  rpn_pkg::word_t    shallow_in,
    input  rpn_pkg::word_t    deep_in,
    output rpn_pkg::word_t    value
);
    import rpn_pkg::*;

    word_t value_reg;
    word_t value_next;

    always_comb
    begin
        unique case (op)
            CELL_SHALLOW: value_next = shallow_in;
            CELL_DEEP:    value_next = deep_in;
            default:      value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

### src/rpn_alu.sv
// Arithmetic unit: add, subtract and multiply in one step, divide one quotient bit per cycle.
`timescale 1ns / 1ps

module rpn_alu
(
    input  logic               clk,
    input  logic               rst_n,
    input  rpn_pkg::alu_ctrl_t ctrl,
    input  rpn_pkg::word_t     lhs,
    input  rpn_pkg::word_t     rhs,
    output logic               done,
    output rpn_pkg::word_t     result
);
    import rpn_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 fix_reg, fix_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    alu_op_t              op_reg, op_next;
    logic                 neg_reg, neg_next;
    word_t                a_reg, a_next;
    word_t                b_reg, b_next;
    word_t                rem_reg, rem_next;
    word_t                quo_reg, quo_next;
    word_t                res_reg, res_next;

    logic [WORD_W:0]      rem_sh;
    logic [WORD_W:0]      trial;
    logic [2*WORD_W-1:0]  product;

    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[WORD_W-1]};
        trial   = rem_sh - {1'b0, b_reg};
        product = a_reg * b_reg;

        busy_next = busy_reg;
        fix_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        neg_next  = neg_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        res_next  = res_reg;

        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            op_next   = ctrl.op;
            rem_next  = '0;
            if (ctrl.op == ALU_DIV)
            begin
                // The divider works on magnitudes; the sign is restored at the end.
                a_next   = lhs[WORD_W-1] ? (WORD_W'(0) - lhs) : lhs;
                b_next   = rhs[WORD_W-1] ? (WORD_W'(0) - rhs) : rhs;
                neg_next = lhs[WORD_W-1] ^ rhs[WORD_W-1];
                quo_next = lhs[WORD_W-1] ? (WORD_W'(0) - lhs) : lhs;
            end
            else
            begin
                a_next   = lhs;
                b_next   = rhs;
                neg_next = 1'b0;
                quo_next = lhs;
            end
        end
        else if (fix_reg)
        begin
            res_next  = neg_reg ? (WORD_W'(0) - quo_reg) : quo_reg;
            done_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (op_reg == ALU_DIV)
            begin
                if (!trial[WORD_W])
                begin
                    rem_next = trial[WORD_W-1:0];
                    quo_next = {quo_reg[WORD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[WORD_W-1:0];
                    quo_next = {quo_reg[WORD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(WORD_W - 1))
                begin
                    busy_next = 1'b0;
                    fix_next  = 1'b1;
                end
            end
            else
            begin
                unique case (op_reg)
                    ALU_ADD: res_next = a_reg + b_reg;
                    ALU_SUB: res_next = a_reg - b_reg;
                    default: res_next = product[WORD_W-1:0];
                endcase
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= ALU_ADD;
        end
        else
        begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

### src/rpn_digit_stack_evaluator.sv
// Top level of the postfix digit stack evaluator: decode, stack cell chain and result register.
`timescale 1ns / 1ps

// Channel   Direction  Payload (lowest bit first)
// s_axis    in         tdata[7:0] symbol
// m_axis    out        tdata[31:0] value, tdata[34:32] status, tdata[39:35] zero
//
// A digit, a space, a colon or any symbol that ends in an error is handled in idle.
// Add, subtract and multiply wait in the calculate state for the arithmetic unit;
// a divide waits longer there, as the divider produces one quotient bit per cycle.
// Reset clears the stack count, the control state and the output valid flag;
// the stack cells themselves hold whatever they held.
// A result waiting on the output does not block input; the output holds up input only
// when a second result is due before the first has been taken.

module rpn_digit_stack_evaluator
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rpn_pkg::SYM_W-1:0]       s_axis_tdata,   // [7:0] symbol
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rpn_pkg::OUT_TDATA_W-1:0] m_axis_tdata    // [31:0] value, [34:32] status
);
    import rpn_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    // The controller waits for input, for the arithmetic unit, or for room to emit.
    typedef enum logic [2:0]
    {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 m_valid_reg, m_valid_next;
    word_t                m_value_reg, m_value_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    word_t                pend_value_reg, pend_value_next;
    logic [STATUS_W-1:0]  pend_status_reg, pend_status_next;

    word_t                cell_value [STACK_DEPTH];
    cell_op_t             cell_op    [STACK_DEPTH];

    logic                 accept;
    logic                 slot_free;
    logic                 do_push;
    logic                 do_pop;
    word_t                load_data;
    logic                 emit;
    word_t                emit_value;
    logic [STATUS_W-1:0]  emit_status;
    alu_ctrl_t            alu_ctrl;
    logic                 alu_done;
    word_t                alu_result;
    logic                 is_digit;
    logic                 is_op;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign slot_free = !m_valid_reg || m_axis_tready;
    assign is_digit  = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
    assign is_op     = (s_axis_tdata == CH_PLUS) || (s_axis_tdata == CH_MINUS) ||
                       (s_axis_tdata == CH_STAR) || (s_axis_tdata == CH_SLASH);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        m_valid_next     = m_valid_reg;
        m_value_next     = m_value_reg;
        m_status_next    = m_status_reg;
        pend_value_next  = pend_value_reg;
        pend_status_next = pend_status_reg;
        do_push          = 1'b0;
        do_pop           = 1'b0;
        load_data        = alu_result;
        emit             = 1'b0;
        emit_value       = '0;
        emit_status      = ST_OK;
        alu_ctrl.start   = 1'b0;
        alu_ctrl.op      = ALU_ADD;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (is_digit)
                    begin
                        if (count_reg == CNT_W'(STACK_DEPTH))
                        begin
                            emit        = 1'b1;
                            emit_status = ST_OVERFLOW;
                        end
                        else
                        begin
                            do_push    = 1'b1;
                            load_data  = WORD_W'(s_axis_tdata - CH_ZERO);
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (s_axis_tdata == CH_SPACE)
                    begin
                        // A space leaves everything as it is.
                    end
                    else if (s_axis_tdata == CH_COLON)
                    begin
                        emit = 1'b1;
                        if (count_reg == '0)
                        begin
                            emit_status = ST_UNDERFLOW;
                        end
                        else
                        begin
                            emit_value = cell_value[0];
                            count_next = '0;
                        end
                    end
                    else if (is_op)
                    begin
                        if (count_reg < CNT_W'(2))
                        begin
                            emit        = 1'b1;
                            emit_status = ST_UNDERFLOW;
                        end
                        else if ((s_axis_tdata == CH_SLASH) && (cell_value[0] == '0))
                        begin
                            emit        = 1'b1;
                            emit_status = ST_DIVZERO;
                        end
                        else
                        begin
                            alu_ctrl.start = 1'b1;
                            unique case (s_axis_tdata)
                                CH_PLUS:  alu_ctrl.op = ALU_ADD;
                                CH_MINUS: alu_ctrl.op = ALU_SUB;
                                CH_STAR:  alu_ctrl.op = ALU_MUL;
                                default:  alu_ctrl.op = ALU_DIV;
                            endcase
                            state_next = S_CALC;
                        end
                    end
                    else
                    begin
                        emit        = 1'b1;
                        emit_status = ST_INVALID;
                    end

                    if (emit)
                    begin
                        if (slot_free)
                        begin
                            m_valid_next  = 1'b1;
                            m_value_next  = emit_value;
                            m_status_next = emit_status;
                        end
                        else
                        begin
                            pend_value_next  = emit_value;
                            pend_status_next = emit_status;
                            state_next       = S_EMIT;
                        end
                    end
                end
            end

            S_CALC:
            begin
                // The two top cells collapse into one holding the result.
                if (alu_done)
                begin
                    do_pop     = 1'b1;
                    load_data  = alu_result;
                    count_next = count_reg - 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    m_valid_next  = 1'b1;
                    m_value_next  = pend_value_reg;
                    m_status_next = pend_status_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Cell 0 is the top of the stack. A push moves every entry one place deeper;
    // a pop moves every entry one place up, and cell 0 takes the new value.
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        word_t shallow;
        word_t deep;

        if (i == 0)
        begin : g_top
            assign shallow = load_data;
        end
        else
        begin : g_inner
            assign shallow = cell_value[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_bottom
            assign deep = cell_value[i];
        end
        else
        begin : g_above
            assign deep = cell_value[i+1];
        end

        always_comb
        begin
            if (do_push)
            begin
                cell_op[i] = CELL_SHALLOW;
            end
            else if (do_pop)
            begin
                cell_op[i] = (i == 0) ? CELL_SHALLOW : CELL_DEEP;
            end
            else
            begin
                cell_op[i] = CELL_HOLD;
            end
        end

        rpn_cell u_cell
        (
            .clk        (clk),
            .op         (cell_op[i]),
            .shallow_in (shallow),
            .deep_in    (deep),
            .value      (cell_value[i])
        );
    end

    // The top entry is the right operand, the one below it the left.
    rpn_alu u_alu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (alu_ctrl),
        .lhs    (cell_value[1]),
        .rhs    (cell_value[0]),
        .done   (alu_done),
        .result (alu_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_value_reg     <= m_value_next;
        m_status_reg    <= m_status_next;
        pend_value_reg  <= pend_value_next;
        pend_status_reg <= pend_status_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - WORD_W - STATUS_W)'(0), m_status_reg, m_value_reg};

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the postfix digit stack evaluator, with a cycle-free predictor.
`timescale 1ns / 1ps

module tb_top;

    import rpn_pkg::*;

    localparam int STACK_DEPTH    = 16;
    localparam int CLK_HALF_NS    = 5;
    localparam int RESET_CYCLES   = 4;
    // A divide is the slowest operation, and this many quiet cycles after the last
    // expected result covers any operation still in flight.
    localparam int DRAIN_CYCLES   = 48;
    localparam int LONG_HOLD      = 300;
    localparam int RANDOM_SYMBOLS = 1500;
    localparam int REPORT_LIMIT   = 10;
    // Worst case is about 1800 symbols, each taking a divide, the longest sender
    // gap and the longest receiver stall; this is a few times that.
    localparam longint TIMEOUT_NS = 64'd10_000_000;

    // One result as it travels on the output stream.
    typedef struct packed
    {
        word_t               value;
        logic [STATUS_W-1:0] status;
    } outcome_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [SYM_W-1:0]       s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Predictor state: the operand stack as the block should hold it after
    // every accepted symbol so far.
    word_t    eval_stack [STACK_DEPTH];
    int       eval_depth = 0;
    outcome_t expected_outcomes [$];

    int symbols_sent    = 0;
    int results_checked = 0;
    int mismatch_count  = 0;
    int status_tally [8];

    // When set, the sender inserts no idle cycles and the sink no random stalls.
    bit steady_flow       = 1'b0;
    // Asks the result sink to hold tready low for a long stretch.
    bit long_hold_request = 1'b0;

    always #CLK_HALF_NS clk = ~clk;

    rpn_digit_stack_evaluator
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] symbol
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [31:0] value, [34:32] status, [39:35] zero
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Signed division that truncates toward zero, done on magnitudes so that
    // the most negative value divided by minus one wraps back onto itself.
    function automatic word_t quotient_toward_zero(input word_t lhs, input word_t rhs);
        logic  neg_lhs;
        logic  neg_rhs;
        word_t mag_lhs;
        word_t mag_rhs;
        word_t mag_q;
        neg_lhs = lhs[WORD_W-1];
        neg_rhs = rhs[WORD_W-1];
        mag_lhs = neg_lhs ? (word_t'(0) - lhs) : lhs;
        mag_rhs = neg_rhs ? (word_t'(0) - rhs) : rhs;
        mag_q   = mag_lhs / mag_rhs;
        return (neg_lhs != neg_rhs) ? (word_t'(0) - mag_q) : mag_q;
    endfunction

    task automatic queue_outcome(input word_t value, input logic [STATUS_W-1:0] status);
        outcome_t item;
        item.value  = value;
        item.status = status;
        expected_outcomes.push_back(item);
    endtask

    // Applies one accepted symbol to the predicted stack and queues the result
    // it causes, if any. Errors leave the stack as it was; only a colon clears it.
    task automatic evaluate_symbol(input logic [SYM_W-1:0] sym);
        word_t lhs;
        word_t rhs;
        word_t res;
        case (sym)
            CH_SPACE:
                ;
            CH_COLON:
                if (eval_depth == 0)
                    queue_outcome('0, ST_UNDERFLOW);
                else
                begin
                    queue_outcome(eval_stack[eval_depth - 1], ST_OK);
                    eval_depth = 0;
                end
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH:
                if (eval_depth < 2)
                    queue_outcome('0, ST_UNDERFLOW);
                else
                begin
                    rhs = eval_stack[eval_depth - 1];
                    lhs = eval_stack[eval_depth - 2];
                    if (sym == CH_SLASH && rhs == '0)
                        queue_outcome('0, ST_DIVZERO);
                    else
                    begin
                        case (sym)
                            CH_PLUS:  res = lhs + rhs;
                            CH_MINUS: res = lhs - rhs;
                            CH_STAR:  res = lhs * rhs;
                            default:  res = quotient_toward_zero(lhs, rhs);
                        endcase
                        eval_depth--;
                        eval_stack[eval_depth - 1] = res;
                    end
                end
            default:
                if (sym >= CH_ZERO && sym <= CH_NINE)
                begin
                    if (eval_depth >= STACK_DEPTH)
                        queue_outcome('0, ST_OVERFLOW);
                    else
                    begin
                        eval_stack[eval_depth] = {{(WORD_W-SYM_W){1'b0}}, sym - CH_ZERO};
                        eval_depth++;
                    end
                end
                else
                    queue_outcome('0, ST_INVALID);
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Idle length between transfers: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        if (steady_flow)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one symbol and holds it until the block takes it. The prediction
    // runs at the edge of the transfer, so results are queued in input order.
    // With no gap, tvalid simply stays high into the next call.
    task automatic send_symbol(input logic [SYM_W-1:0] sym);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        do
            @(posedge clk);
        while (!s_axis_tready);
        evaluate_symbol(sym);
        symbols_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= SYM_W'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering and waits until every queued result has come out, then
    // long enough for any operation that makes no result to finish.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SYM_W-1:0] digit_symbol(input int unsigned n);
        return CH_ZERO + SYM_W'(n);
    endfunction

    function automatic logic [SYM_W-1:0] random_digit();
        return digit_symbol($urandom_range(0, 9));
    endfunction

    function automatic logic [SYM_W-1:0] random_operator();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // Sometimes puts a space in front, which the block must skip.
    task automatic send_spaced(input logic [SYM_W-1:0] sym);
        if ($urandom_range(0, 5) == 0)
            send_symbol(CH_SPACE);
        send_symbol(sym);
    endtask

    // A well-formed expression with random digits and operators, reduced to a
    // single entry and closed by a colon. A zero on top can still make a divide fail.
    task automatic send_expression(input int max_pushes);
        int pushes;
        int guard;
        pushes = $urandom_range(1, max_pushes);
        guard  = 0;
        while ((pushes > 0 || eval_depth > 1) && guard < 4 * STACK_DEPTH)
        begin
            guard++;
            if (eval_depth >= 2 &&
                (pushes == 0 || eval_depth >= STACK_DEPTH || $urandom_range(0, 2) == 0))
                send_spaced(random_operator());
            else
            begin
                send_spaced(random_digit());
                pushes--;
            end
        end
        send_spaced(CH_COLON);
    endtask

    // Builds 2^31 as ten eights and a two multiplied together, which wraps to
    // the most negative value, then divides it by minus one.
    task automatic send_most_negative_quotient();
        send_spaced(digit_symbol(8));
        repeat (9)
        begin
            send_spaced(digit_symbol(8));
            send_spaced(CH_STAR);
        end
        send_spaced(digit_symbol(2));
        send_spaced(CH_STAR);
        send_spaced(CH_ZERO);
        send_spaced(digit_symbol(1));
        send_spaced(CH_MINUS);
        send_spaced(CH_SLASH);
        send_spaced(CH_COLON);
    endtask

    // Fills the stack, pushes past the top, then folds part of it and emits.
    task automatic send_stack_overflow();
        while (eval_depth < STACK_DEPTH)
            send_spaced(random_digit());
        repeat ($urandom_range(1, 3)) send_spaced(random_digit());
        repeat ($urandom_range(0, STACK_DEPTH)) send_spaced(random_operator());
        send_spaced(CH_COLON);
    endtask

    // Short sequences that go wrong in one of the usual ways.
    task automatic send_broken_sequence();
        case ($urandom_range(0, 3))
            0:
            begin
                send_spaced(CH_COLON);
                send_spaced(CH_COLON);
            end
            1:
            begin
                send_spaced(random_digit());
                send_spaced(random_operator());
                send_spaced(random_operator());
            end
            2:
            begin
                send_spaced(random_digit());
                send_spaced(CH_ZERO);
                send_spaced(CH_SLASH);
                send_spaced(CH_COLON);
            end
            default:
            begin
                send_spaced(random_digit());
                send_symbol(SYM_W'($urandom));
                send_spaced(CH_COLON);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Result sink: random stalls, a long hold when asked, none in steady flow.
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (long_hold_request)
            begin
                long_hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                hold_left = LONG_HOLD - 1;
            end
            else if (steady_flow)
                m_axis_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                             : $urandom_range(1, 3);
            end
        end
    end

    // Compares every output transfer with the oldest queued result.
    initial
    begin : result_check
        outcome_t               want;
        word_t                  got_value;
        logic [STATUS_W-1:0]    got_status;
        logic [OUT_TDATA_W-1:0] got_pad;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got_value  = m_axis_tdata[WORD_W-1:0];
                got_status = m_axis_tdata[WORD_W+STATUS_W-1:WORD_W];
                got_pad    = m_axis_tdata >> (WORD_W + STATUS_W);
                if (expected_outcomes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("Unexpected result at %0t ns: value %0d status %0d",
                                 $realtime, $signed(got_value), got_status);
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    results_checked++;
                    status_tally[got_status]++;
                    if (got_value !== want.value || got_status !== want.status ||
                        got_pad !== '0)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("Result %0d at %0t ns: expected value %0d status %0d, got value %0d status %0d pad %0h",
                                     results_checked, $realtime, $signed(want.value),
                                     want.status, $signed(got_value), got_status, got_pad);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Invalid symbols at both ends of the byte range and beside the valid
    // codes, operators and colon on an empty stack, an operator on a single entry.
    task automatic test_error_symbols();
        send_symbol(CH_COLON);
        send_symbol(CH_PLUS);
        send_symbol(digit_symbol(9));
        send_symbol(CH_SLASH);
        send_symbol('0);
        send_symbol('1);
        send_symbol(CH_SLASH - 1'b1);
        send_symbol(CH_COLON + 1'b1);
        send_symbol(CH_SPACE);
        send_symbol(CH_COLON);
    endtask

    // Every operator once, with a divide by zero that must leave the stack alone.
    task automatic test_basic_operators();
        send_symbol(digit_symbol(9));
        send_symbol(CH_ZERO);
        send_symbol(CH_SLASH);
        send_symbol(CH_MINUS);
        send_symbol(digit_symbol(7));
        send_symbol(CH_STAR);
        send_symbol(digit_symbol(4));
        send_symbol(CH_SLASH);
        send_symbol(digit_symbol(8));
        send_symbol(CH_PLUS);
        send_symbol(CH_COLON);
    endtask

    // A negative odd dividend, so truncation toward zero shows.
    task automatic test_truncating_division();
        send_symbol(CH_ZERO);
        send_symbol(digit_symbol(7));
        send_symbol(CH_MINUS);
        send_symbol(digit_symbol(2));
        send_symbol(CH_SLASH);
        send_symbol(CH_COLON);
    endtask

    // The sink holds off for a long stretch while the source keeps offering, so
    // a second result backs up behind the first and the input stalls.
    task automatic test_output_backpressure();
        steady_flow       = 1'b1;
        long_hold_request = 1'b1;
        repeat (12) send_expression(4);
        steady_flow = 1'b0;
        wait_for_drain();
    endtask

    // The source goes quiet after each expression until its result is out.
    task automatic test_drain_pause();
        repeat (4)
        begin
            send_expression(3);
            wait_for_drain();
        end
    endtask

    // Mostly well-formed expressions, with noise bytes, broken sequences,
    // full-stack runs and the wrapping divide mixed in. Steady stretches come
    // and go at random.
    task automatic test_random_stream();
        int start_count;
        int choice;
        start_count = symbols_sent;
        send_most_negative_quotient();
        send_stack_overflow();
        while (symbols_sent - start_count < RANDOM_SYMBOLS)
        begin
            if ($urandom_range(0, 24) == 0)
                steady_flow = !steady_flow;
            choice = $urandom_range(0, 99);
            if (choice < 68)
                send_expression(($urandom_range(0, 9) == 0) ? STACK_DEPTH : 6);
            else if (choice < 78)
                repeat ($urandom_range(1, 3)) send_symbol(SYM_W'($urandom_range(0, 255)));
            else if (choice < 94)
                send_broken_sequence();
            else if (choice < 97)
                send_stack_overflow();
            else
                send_most_negative_quotient();
        end
        steady_flow = 1'b0;
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------

    initial
    begin : test_sequence
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_error_symbols();
        wait_for_drain();
        test_basic_operators();
        test_truncating_division();
        wait_for_drain();
        test_output_backpressure();
        test_drain_pause();
        test_random_stream();

        $display("Covered %0d symbols and %0d results: %0d values, %0d invalid, %0d underflow, %0d overflow, %0d divide by zero",
                 symbols_sent, results_checked, status_tally[ST_OK], status_tally[ST_INVALID],
                 status_tally[ST_UNDERFLOW], status_tally[ST_OVERFLOW],
                 status_tally[ST_DIVZERO]);
        $display("Output held off for %0d cycles once; %0d result errors counted",
                 LONG_HOLD, mismatch_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Run stopped by the watchdog with %0d results outstanding",
                 expected_outcomes.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
src/rpn_pkg.sv
src/rpn_cell.sv
src/rpn_alu.sv
src/rpn_digit_stack_evaluator.sv
tb/sv/tb_top.sv
